@@ rtl/periodic_task_timer_table_assert.svh @@
// Assertion macros for the periodic task timer table.
// No dependencies; included by modules that carry assertions.
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH

// Clocked implication, disabled during reset.
`define PTT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Clocked next-cycle implication, disabled during reset.
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/ptt_pkg.sv @@
// Shared types and codes for the periodic task timer table.
// No dependencies.
`timescale 1ns / 1ps
package ptt_pkg;
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_ADD    = 3'd1;
  localparam logic [2:0] FUNC_REMOVE = 3'd2;
  localparam logic [2:0] FUNC_SETACT = 3'd3;
  localparam logic [2:0] FUNC_SETRT  = 3'd4;
  localparam logic [2:0] FUNC_QUERY  = 3'd5;

  localparam logic [1:0] KIND_FIRE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_OP   = 2'd2;

  localparam logic CFG_INIT = 1'b0;
  localparam logic CFG_RUN  = 1'b1;

  // One table entry as held in memory.
  typedef struct packed {
    logic [15:0] hnd;
    logic [31:0] rate;
    logic [31:0] accum;
    logic        active;
    logic [31:0] tag;
  } entry_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [15:0] task_handle;
    logic [31:0] accumulated;
    logic [31:0] task_rate;
    logic        task_active;
    logic [31:0] tag_out;
    logic        last;
  } result_t;
endpackage

@@ rtl/ptt_out_reg.sv @@
// Output register stage for result beats.
// Depends on ptt_pkg.
`timescale 1ns / 1ps
module ptt_out_reg
  import ptt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t out_data
);
  logic    valid_r;
  result_t data_r;

  assign full       = valid_r && !out_tready;
  assign out_tvalid = valid_r;
  assign out_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
    if (push) begin
      data_r <= push_data;
    end
  end
endmodule

@@ rtl/periodic_task_timer_table.sv @@
// Periodic task timer table. Operations come in one beat at a time, the code in
// in_tuser, and no new beat is taken until every result of the current one has
// gone into the output register. Add, unknown codes and refused or idle ticks go
// straight to the done state. A lookup (remove, set_active, set_rate, query) reads
// and then evaluates each entry visited in the entry memory. A remove then moves
// each later entry down. A running tick visits every entry. Output back-pressure
// stalls the table; a result appears on the output the cycle after it is produced.
// Depends on ptt_pkg.
`timescale 1ns / 1ps
module periodic_task_timer_table
  import ptt_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // elapsed[15:0], handle[31:16], rate[63:32], user_tag[95:64], active_flag[96],
  // zero pad to 104
  input  logic [103:0] in_tdata,
  // func[2:0]
  input  logic [2:0]   in_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic         cfg_data,
  output logic         out_tvalid,
  input  logic         out_tready,
  // ok[0], task_handle[16:1], accumulated[48:17], task_rate[80:49],
  // task_active[81], tag_out[113:82], zero pad to 120
  output logic [119:0] out_tdata,
  // kind[1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);
`include "periodic_task_timer_table_assert.svh"

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EVAL, S_SHIFT, S_MOVE, S_DONE
  } state_t;

  entry_t mem [MAX_TASKS];
  entry_t rd_r;

  state_t       state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [15:0]  nfh_r;
  logic         init_r, run_r;
  logic         found_r;
  logic [2:0]   func_r;
  logic [15:0]  elapsed_r, hnd_r;
  logic [31:0]  rate_r;
  logic         flag_r;

  logic    push, full;
  result_t push_d, out_d;

  logic        we;
  logic [IW-1:0] waddr, raddr;
  entry_t      wdata;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);

  // saturating accumulate on the entry just read
  logic [32:0] sum;
  logic [31:0] acc_sat;
  assign sum     = {1'b0, rd_r.accum} + {17'd0, elapsed_r};
  assign acc_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  logic hit;
  assign hit = (rd_r.hnd == hnd_r);

  assign raddr = (state_r == S_SHIFT) ? IW'(idx_r + 1'b1) : idx_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_comb begin
    push   = 1'b0;
    push_d = '0;
    we     = 1'b0;
    waddr  = idx_r[IW-1:0];
    wdata  = rd_r;
    if (state_r == S_EVAL && !full) begin
      if (func_r == FUNC_TICK) begin
        if (rd_r.active) begin
          we          = 1'b1;
          wdata.accum = acc_sat;
          if (acc_sat >= rd_r.rate) begin
            push               = 1'b1;
            push_d.kind        = KIND_FIRE;
            push_d.ok          = 1'b1;
            push_d.task_handle = rd_r.hnd;
            push_d.accumulated = acc_sat;
            push_d.tag_out     = rd_r.tag;
            wdata.accum        = acc_sat - rd_r.rate;
          end
        end
      end else if (hit) begin
        case (func_r)
          FUNC_SETACT: begin we = 1'b1; wdata.active = flag_r; end
          FUNC_SETRT:  begin we = 1'b1; wdata.rate = rate_r; end
          default: ;
        endcase
      end
    end
    // entry idx+1 was read in S_SHIFT; store it at idx
    if (state_r == S_MOVE) begin
      we    = 1'b1;
      wdata = rd_r;
    end
    if (state_r == S_IDLE && in_tvalid && in_tuser == FUNC_ADD
        && count_r < CW'(MAX_TASKS)) begin
      we           = 1'b1;
      waddr        = count_r[IW-1:0];
      wdata.hnd    = nfh_r;
      wdata.rate   = in_tdata[63:32];
      wdata.accum  = '0;
      wdata.active = 1'b0;
      wdata.tag    = in_tdata[95:64];
    end
    if (state_r == S_DONE && !full) begin
      push               = 1'b1;
      push_d.last        = 1'b1;
      push_d.task_handle = hnd_r;
      push_d.ok          = found_r;
      case (func_r)
        FUNC_TICK: begin push_d.kind = KIND_TICK; push_d.task_handle = '0; end
        FUNC_QUERY: begin
          push_d.kind = KIND_OP;
          if (found_r) begin
            push_d.accumulated = rd_r.accum;
            push_d.task_rate   = rd_r.rate;
            push_d.task_active = rd_r.active;
            push_d.tag_out     = rd_r.tag;
          end
        end
        default: push_d.kind = KIND_OP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      nfh_r   <= 16'd1;
      init_r  <= 1'b0;
      run_r   <= 1'b0;
      idx_r   <= '0;
      found_r <= 1'b0;
      func_r  <= FUNC_TICK;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_INIT) init_r <= cfg_data;
        else run_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          func_r    <= in_tuser;
          elapsed_r <= in_tdata[15:0];
          hnd_r     <= in_tdata[31:16];
          rate_r    <= in_tdata[63:32];
          flag_r    <= in_tdata[96];
          idx_r     <= '0;
          found_r   <= 1'b0;
          case (in_tuser)
            FUNC_TICK: begin
              found_r <= init_r;
              state_r <= (init_r && run_r && count_r != '0) ? S_READ : S_DONE;
            end
            FUNC_ADD: begin
              if (count_r < CW'(MAX_TASKS)) begin
                found_r <= 1'b1;
                count_r <= count_r + 1'b1;
                nfh_r   <= nfh_r + 16'd1;
              end
              hnd_r   <= (count_r < CW'(MAX_TASKS)) ? nfh_r : 16'd0;
              state_r <= S_DONE;
            end
            FUNC_REMOVE, FUNC_SETACT, FUNC_SETRT, FUNC_QUERY:
              state_r <= (count_r != '0) ? S_READ : S_DONE;
            default: state_r <= S_DONE;
          endcase
        end
        S_READ: state_r <= S_EVAL;
        S_EVAL: if (!full) begin
          if (func_r == FUNC_TICK) begin
            if (idx_r + 1'b1 < count_r) begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_READ;
            end else begin
              state_r <= S_DONE;
            end
          end else if (hit) begin
            found_r <= 1'b1;
            if (func_r == FUNC_REMOVE) begin
              if (idx_r + 1'b1 < count_r) begin
                state_r <= S_SHIFT;
              end else begin
                count_r <= count_r - 1'b1;
                state_r <= S_DONE;
              end
            end else begin
              state_r <= S_DONE;
            end
          end else if (idx_r + 1'b1 < count_r) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_READ;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SHIFT: state_r <= S_MOVE;
        S_MOVE: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r + CW'(2) < count_r) begin
            state_r <= S_SHIFT;
          end else begin
            count_r <= count_r - 1'b1;
            state_r <= S_DONE;
          end
        end
        S_DONE: if (!full) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ptt_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_d),
    .full      (full),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_data  (out_d)
  );

  assign out_tdata = {6'd0, out_d.tag_out, out_d.task_active, out_d.task_rate,
                      out_d.accumulated, out_d.task_handle, out_d.ok};
  assign out_tuser = out_d.kind;
  assign out_tlast = out_d.last;

  `PTT_ASSERT_IMPL(a_busy_no_ready, state_r != S_IDLE, !in_tready)
  `PTT_ASSERT_IMPL(a_count_range, 1'b1, count_r <= CW'(MAX_TASKS))
  `PTT_ASSERT_NEXT(a_done_last, state_r == S_DONE && !full, out_tvalid && out_tlast)
endmodule
